[design/base64_chunk_frame_reassembler_macros.svh]
// Assertion macros shared by the base64 chunk frame reassembler RTL.
// Expects i_clk and i_rst_n in the scope of the module that uses them.
`ifndef BASE64_CHUNK_FRAME_REASSEMBLER_MACROS_SVH
`define BASE64_CHUNK_FRAME_REASSEMBLER_MACROS_SVH

// Property checked in the same cycle as its antecedent.
`define B64R_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("b64r assertion failed");

// Property checked in the cycle after its antecedent.
`define B64R_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("b64r assertion failed");

`endif

[design/b64r_pkg.sv]
// Package of the base64 chunk frame reassembler: widths, codes, types and
// the base64 alphabet map. No dependencies.
package b64r_pkg;

    localparam int FRAME_BYTES = 8192;
    localparam int ADDR_W      = 13;
    localparam int CNT_W       = 14;
    localparam int CHUNK_W     = 10;
    localparam int TOTAL_W     = 11;
    localparam int IDLE_W      = 16;
    localparam int PROD_W      = CHUNK_W + CNT_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 24;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_CHAR   = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_TICK   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

    typedef struct packed {
        logic               valid;
        logic [1:0]         kind;
        logic [CHUNK_W-1:0] chunk_number;
        logic [TOTAL_W-1:0] announced_total;
        logic [7:0]         text_char;
        logic [PROD_W-1:0]  offset;
    } t_stage;

    // Returns {in_alphabet, sextet}.
    function automatic logic [6:0] sextet_of(input logic [7:0] ch);
        logic [6:0] r;
        r = 7'd0;
        if (ch inside {[8'h41:8'h5A]}) begin
            r = {1'b1, 6'(ch - 8'h41)};
        end else if (ch inside {[8'h61:8'h7A]}) begin
            r = {1'b1, 6'(ch - 8'h61 + 8'd26)};
        end else if (ch inside {[8'h30:8'h39]}) begin
            r = {1'b1, 6'(ch - 8'h30 + 8'd52)};
        end else if (ch == 8'h2B) begin
            r = {1'b1, 6'd62};
        end else if (ch == 8'h2F) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

endpackage

[design/b64r_in_stage.sv]
// Input register of the reassembler; also forms the chunk byte offset.
// Depends on b64r_pkg.
module b64r_in_stage (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // kind
    input  logic [1:0]                       i_s_axis_tuser,
    // chunk_number, announced_total, text_char, zero pad
    input  logic [b64r_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    input  logic [b64r_pkg::CNT_W-1:0]       i_chunk_byte_count,
    input  logic                             i_advance,
    output b64r_pkg::t_stage                 o_stage
);

    b64r_pkg::t_stage r_stage;
    logic             w_load;
    logic [b64r_pkg::CHUNK_W-1:0] w_num;

    assign o_s_axis_tready = !r_stage.valid || i_advance;
    assign w_load          = i_s_axis_tvalid && o_s_axis_tready;
    assign w_num           = i_s_axis_tdata[b64r_pkg::CHUNK_W-1:0];
    assign o_stage         = r_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_stage.valid <= i_s_axis_tvalid;
        end
        if (w_load) begin
            r_stage.kind            <= i_s_axis_tuser;
            r_stage.chunk_number    <= w_num;
            r_stage.announced_total <= i_s_axis_tdata[20:10];
            r_stage.text_char       <= i_s_axis_tdata[28:21];
            r_stage.offset          <= b64r_pkg::PROD_W'(w_num)
                                     * b64r_pkg::PROD_W'(i_chunk_byte_count);
        end
    end

endmodule

[design/b64r_core.sv]
// Frame state, configuration registers and result register of the
// reassembler. Depends on b64r_pkg.
module b64r_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [b64r_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [b64r_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  b64r_pkg::t_stage                   i_stage,
    output logic                               o_ready,
    output logic [b64r_pkg::CNT_W-1:0]         o_chunk_byte_count,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // write_valid, chunk_accepted, frame_complete
    output logic [2:0]                         o_m_axis_tuser,
    // write_address, write_byte, zero pad
    output logic [b64r_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);

    logic [b64r_pkg::TOTAL_W-1:0] r_total_cfg;
    logic [b64r_pkg::CNT_W-1:0]   r_bytes_cfg;
    logic [b64r_pkg::IDLE_W-1:0]  r_timeout_cfg;

    logic [b64r_pkg::CHUNK_W-1:0] r_expected, n_expected;
    logic [b64r_pkg::IDLE_W-1:0]  r_idle, n_idle;
    logic                         r_active, n_active;
    logic [b64r_pkg::CHUNK_W-1:0] r_current, n_current;
    logic                         r_last, n_last;
    logic [b64r_pkg::ADDR_W-1:0]  r_addr, n_addr;
    logic [b64r_pkg::CNT_W-1:0]   r_left, n_left;
    logic [11:0]                  r_acc, n_acc;
    logic [3:0]                   r_bits, n_bits;

    logic                         r_out_v;
    logic                         r_wv, n_wv;
    logic [b64r_pkg::ADDR_W-1:0]  r_wa, n_wa;
    logic [7:0]                   r_wb, n_wb;
    logic                         r_ok, n_ok;
    logic                         r_done, n_done;

    logic                         w_step;
    logic [6:0]                   w_sextet;
    logic [11:0]                  w_acc;
    logic [3:0]                   w_bits;
    logic [b64r_pkg::CNT_W-1:0]   w_rem;
    logic [b64r_pkg::CNT_W-1:0]   w_cap;
    logic                         w_past_end;
    logic [b64r_pkg::TOTAL_W-1:0] w_num_plus;

    assign o_ready            = !r_out_v || i_m_axis_tready;
    assign w_step             = i_stage.valid && o_ready;
    assign o_chunk_byte_count = r_bytes_cfg;
    assign o_m_axis_tvalid    = r_out_v;
    assign o_m_axis_tuser     = {r_done, r_ok, r_wv};
    assign o_m_axis_tdata     = {3'd0, r_wb, r_wa};

    assign w_sextet   = b64r_pkg::sextet_of(i_stage.text_char);
    assign w_acc      = {r_acc[5:0], w_sextet[5:0]};
    assign w_bits     = r_bits + 4'd6;
    assign w_past_end = i_stage.offset >= b64r_pkg::PROD_W'(b64r_pkg::FRAME_BYTES);
    assign w_rem      = b64r_pkg::CNT_W'(b64r_pkg::FRAME_BYTES)
                      - {1'b0, i_stage.offset[b64r_pkg::ADDR_W-1:0]};
    assign w_cap      = w_past_end ? '0
                      : ((w_rem > r_bytes_cfg) ? r_bytes_cfg : w_rem);
    assign w_num_plus = b64r_pkg::TOTAL_W'(i_stage.chunk_number) + 11'd1;

    always_comb begin
        n_expected = r_expected;
        n_idle     = r_idle;
        n_active   = r_active;
        n_current  = r_current;
        n_last     = r_last;
        n_addr     = r_addr;
        n_left     = r_left;
        n_acc      = r_acc;
        n_bits     = r_bits;
        n_wv       = 1'b0;
        n_wa       = '0;
        n_wb       = '0;
        n_ok       = 1'b0;
        n_done     = 1'b0;
        case (i_stage.kind)
            b64r_pkg::KIND_TICK: begin
                if (r_idle != '1) begin
                    n_idle = r_idle + 16'd1;
                end
            end
            b64r_pkg::KIND_HEADER: begin
                n_active = 1'b0;
                n_ok     = 1'b1;
                if (r_expected != '0 && r_idle > r_timeout_cfg) begin
                    n_expected = '0;
                end
                if (i_stage.announced_total != r_total_cfg
                        || i_stage.chunk_number != n_expected) begin
                    if (i_stage.chunk_number == '0) begin
                        n_expected = '0;
                    end else begin
                        n_ok = 1'b0;
                    end
                end
                if (n_ok) begin
                    if (w_cap == '0) begin
                        n_ok = 1'b0;
                    end else begin
                        n_active  = 1'b1;
                        n_current = i_stage.chunk_number;
                        n_last    = (w_num_plus == i_stage.announced_total);
                        n_addr    = i_stage.offset[b64r_pkg::ADDR_W-1:0];
                        n_left    = w_cap;
                        n_acc     = '0;
                        n_bits    = '0;
                    end
                end
            end
            b64r_pkg::KIND_CHAR: begin
                if (r_active && r_left != '0 && w_sextet[6]) begin
                    n_acc  = w_acc;
                    n_bits = w_bits;
                    if (w_bits >= 4'd8) begin
                        n_bits = w_bits - 4'd8;
                        n_wv   = 1'b1;
                        n_wa   = r_addr;
                        n_wb   = 8'(w_acc >> n_bits);
                        n_addr = r_addr + 13'd1;
                        n_left = r_left - 14'd1;
                    end
                end
            end
            default: begin
                if (r_active) begin
                    n_active   = 1'b0;
                    n_idle     = '0;
                    n_expected = r_current + 10'd1;
                    if (r_last) begin
                        n_done     = 1'b1;
                        n_expected = '0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_cfg   <= 11'd16;
            r_bytes_cfg   <= 14'd512;
            r_timeout_cfg <= 16'd500;
            r_expected    <= '0;
            r_idle        <= '0;
            r_active      <= 1'b0;
            r_current     <= '0;
            r_last        <= 1'b0;
            r_addr        <= '0;
            r_left        <= '0;
            r_acc         <= '0;
            r_bits        <= '0;
            r_out_v       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    b64r_pkg::REG_TOTAL:   r_total_cfg   <= i_cfg_data[10:0];
                    b64r_pkg::REG_BYTES:   r_bytes_cfg   <= i_cfg_data[13:0];
                    b64r_pkg::REG_TIMEOUT: r_timeout_cfg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_ready) begin
                r_out_v <= i_stage.valid;
            end
            if (w_step) begin
                r_expected <= n_expected;
                r_idle     <= n_idle;
                r_active   <= n_active;
                r_current  <= n_current;
                r_last     <= n_last;
                r_addr     <= n_addr;
                r_left     <= n_left;
                r_acc      <= n_acc;
                r_bits     <= n_bits;
            end
        end
        if (w_step) begin
            r_wv   <= n_wv;
            r_wa   <= n_wa;
            r_wb   <= n_wb;
            r_ok   <= n_ok;
            r_done <= n_done;
        end
    end

endmodule

[design/base64_chunk_frame_reassembler.sv]
// Top level of the base64 chunk frame reassembler.
// Depends on b64r_pkg, b64r_in_stage, b64r_core and the macros header.
//
// The block takes one transaction per clock while the output is not stalled
// and returns exactly one result transaction for each, through the input
// register and then the result register. The first stage registers the item
// and forms the chunk's byte offset with a 10 by 14 bit multiply; the second
// stage updates the frame state and loads the result register, so the
// sustained rate is one item per cycle without stalls, set by that state update loop.
`include "base64_chunk_frame_reassembler_macros.svh"

module base64_chunk_frame_reassembler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [b64r_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [b64r_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // kind
    input  logic [1:0]                         i_s_axis_tuser,
    // chunk_number, announced_total, text_char, zero pad
    input  logic [b64r_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // write_valid, chunk_accepted, frame_complete
    output logic [2:0]                         o_m_axis_tuser,
    // write_address, write_byte, zero pad
    output logic [b64r_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);

    b64r_pkg::t_stage             w_stage;
    logic                         w_core_ready;
    logic [b64r_pkg::CNT_W-1:0]   w_bytes_cfg;

    b64r_in_stage u_in_stage (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_s_axis_tvalid    (i_s_axis_tvalid),
        .o_s_axis_tready    (o_s_axis_tready),
        .i_s_axis_tuser     (i_s_axis_tuser),
        .i_s_axis_tdata     (i_s_axis_tdata),
        .i_chunk_byte_count (w_bytes_cfg),
        .i_advance          (w_core_ready),
        .o_stage            (w_stage)
    );

    b64r_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_stage            (w_stage),
        .o_ready            (w_core_ready),
        .o_chunk_byte_count (w_bytes_cfg),
        .o_m_axis_tvalid    (o_m_axis_tvalid),
        .i_m_axis_tready    (i_m_axis_tready),
        .o_m_axis_tuser     (o_m_axis_tuser),
        .o_m_axis_tdata     (o_m_axis_tdata)
    );

    `B64R_ASSERT_NEXT(a_input_lands, i_s_axis_tvalid && o_s_axis_tready,
                      w_stage.valid)
    `B64R_ASSERT_NEXT(a_stage_holds, w_stage.valid && !w_core_ready,
                      w_stage.valid && $stable(w_stage.offset))
    `B64R_ASSERT_SAME(a_done_alone, o_m_axis_tvalid && o_m_axis_tuser[2],
                      !o_m_axis_tuser[0] && !o_m_axis_tuser[1])

endmodule
